// ===== rtl/gmt_pkg.sv =====
// Shared types, codes and constants of the GF(2) Moebius transform engine.
`timescale 1ns / 1ps

package gmt_pkg;

    // Bits per table word and its base-two logarithm.
    localparam int WORD_BITS = 64;
    localparam int LOG_WORD  = 6;

    // Default for the largest supported variable count.
    localparam int MAX_VARS_DEF = 16;

    // Field widths.
    localparam int REQ_W = 2;
    localparam int IDX_W = 10;
    localparam int NV_W  = 5;
    localparam int ST_W  = 2;

    // Variable count after reset.
    localparam logic [NV_W-1:0] NUM_VARS_RST = NV_W'(6);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_XFORM = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_WRITE = 2'd0;
    localparam logic [ST_W-1:0] ST_READ  = 2'd1;
    localparam logic [ST_W-1:0] ST_XFORM = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [IDX_W-1:0]     word_index;
        logic [WORD_BITS-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic [ST_W-1:0]      status;
    } t_resp;

endpackage

// ===== rtl/gmt_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module gmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gmt_word_xform.sv =====
// In-word Moebius butterflies for the six variables that live inside one table word.
`timescale 1ns / 1ps

module gmt_word_xform (
    input  logic [gmt_pkg::WORD_BITS-1:0] i_word,
    input  logic [2:0]                    i_nv,
    output logic [gmt_pkg::WORD_BITS-1:0] o_word
);

    localparam logic [gmt_pkg::WORD_BITS-1:0] LOW_HALF [gmt_pkg::LOG_WORD] = '{
        64'h5555555555555555, 64'h3333333333333333, 64'h0F0F0F0F0F0F0F0F,
        64'h00FF00FF00FF00FF, 64'h0000FFFF0000FFFF, 64'h00000000FFFFFFFF
    };

    logic [gmt_pkg::WORD_BITS-1:0] w;
    logic [gmt_pkg::WORD_BITS-1:0] keep;

    // i_nv is the variable count clipped to six; with fewer variables only the
    // low 2^i_nv bits belong to the table and the rest are kept as they were.
    always_comb begin
        w = i_word;
        for (int s = 0; s < gmt_pkg::LOG_WORD; s++) begin
            if (3'(s) < i_nv) begin
                w = w ^ ((w & LOW_HALF[s]) << (1 << s));
            end
        end
        if (i_nv >= 3'(gmt_pkg::LOG_WORD)) begin
            keep = '1;
        end else begin
            keep = (64'(1) << (7'(1) << i_nv)) - 64'(1);
        end
        o_word = (w & keep) | (i_word & ~keep);
    end

endmodule

// ===== rtl/gf2_moebius_transform_engine.sv =====
// Top level of the GF(2) Moebius transform engine: request sequencer around the table RAM.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_in  (gmt_pkg::t_req)
// out      output     o_out_valid / i_out_ready o_out (gmt_pkg::t_resp)
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (num_vars)
//
// A write or a read passes through the response state into the output register.
// A transform with W = max(1, 2^(n-6)) words reads and writes back each word in the
// in-word pass, then for each variable from six to n-1 reads the low and high word of
// each pair and writes the upper word; the single RAM read port sets this order.
// Reset is synchronous and active low; the table contents are not cleared.
// The input is taken only in the idle state; a result waiting on the output does not
// stop the next transfer, but the following result waits until the output is free.

module gf2_moebius_transform_engine #(
    parameter int MAX_VARS = gmt_pkg::MAX_VARS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  gmt_pkg::t_req             i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output gmt_pkg::t_resp            o_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [gmt_pkg::NV_W-1:0]  i_cfg_data
);

    // Table geometry follows from the largest variable count.
    localparam int DEPTH  = 1 << (MAX_VARS - gmt_pkg::LOG_WORD);
    localparam int ADDR_W = (MAX_VARS > gmt_pkg::LOG_WORD) ? (MAX_VARS - gmt_pkg::LOG_WORD) : 1;
    localparam int VAR_W  = $clog2(MAX_VARS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_IW_RD,
        S_IW_WR,
        S_PR_LO,
        S_PR_HI,
        S_PR_WR,
        S_RESP
    } t_state;

    t_state                          r_state;
    logic [gmt_pkg::NV_W-1:0]        r_num_vars;
    logic [VAR_W-1:0]                r_n;
    logic [VAR_W-1:0]                r_k;
    logic [ADDR_W-1:0]               r_j;
    logic [gmt_pkg::WORD_BITS-1:0]   r_lo;
    logic                            r_res_rd;
    logic [gmt_pkg::ST_W-1:0]        r_res_status;
    logic                            r_out_valid;
    gmt_pkg::t_resp                  r_out;

    logic                            in_xfer;
    logic                            in_range;
    logic                            out_free;
    logic [ADDR_W:0]                 words_sh;
    logic [ADDR_W-1:0]               words_m1;
    logic [ADDR_W-1:0]               kbit;
    logic [ADDR_W-1:0]               lo_mask;
    logic [ADDR_W-1:0]               hi_addr;
    logic [ADDR_W-1:0]               lo_addr;
    logic                            last_var;
    logic [2:0]                      nv_clip;

    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr;
    logic [gmt_pkg::WORD_BITS-1:0]   ram_wdata;
    logic                            ram_re;
    logic [ADDR_W-1:0]               ram_raddr;
    logic [gmt_pkg::WORD_BITS-1:0]   ram_rdata;
    logic [gmt_pkg::WORD_BITS-1:0]   xf_word;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign in_range    = (32'(i_in.word_index) < DEPTH);
    assign out_free    = !r_out_valid || i_out_ready;

    // Geometry of the running transform: last word index, and the pair layout for
    // the variable above the word boundary that is being processed (bit k of the index).
    always_comb begin
        if (r_n >= VAR_W'(gmt_pkg::LOG_WORD)) begin
            words_sh = (ADDR_W+1)'(1) << (r_n - VAR_W'(gmt_pkg::LOG_WORD));
            words_m1 = ADDR_W'(words_sh - (ADDR_W+1)'(1));
            nv_clip  = 3'(gmt_pkg::LOG_WORD);
        end else begin
            words_sh = (ADDR_W+1)'(1);
            words_m1 = '0;
            nv_clip  = 3'(r_n);
        end
        kbit     = ADDR_W'(1) << r_k;
        lo_mask  = kbit - ADDR_W'(1);
        // The pair counter gets a zero inserted at bit k; that is the lower word.
        lo_addr  = ((r_j & ~lo_mask) << 1) | (r_j & lo_mask);
        hi_addr  = lo_addr | kbit;
        last_var = ({1'b0, r_k} + (VAR_W+1)'(gmt_pkg::LOG_WORD + 1)) >= {1'b0, r_n};
    end

    // RAM port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_j;
        ram_wdata = xf_word;
        ram_re    = 1'b0;
        ram_raddr = r_j;
        unique case (r_state)
            S_IDLE: begin
                ram_waddr = ADDR_W'(i_in.word_index);
                ram_wdata = i_in.write_data;
                ram_raddr = ADDR_W'(i_in.word_index);
                ram_we    = in_xfer && in_range && (i_in.req_type == gmt_pkg::REQ_WRITE);
                ram_re    = in_xfer && in_range && (i_in.req_type == gmt_pkg::REQ_READ);
            end
            S_IW_RD: begin
                ram_re = 1'b1;
            end
            S_IW_WR: begin
                ram_we = 1'b1;
            end
            S_PR_LO: begin
                ram_re    = 1'b1;
                ram_raddr = lo_addr;
            end
            S_PR_HI: begin
                ram_re    = 1'b1;
                ram_raddr = hi_addr;
            end
            S_PR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = hi_addr;
                ram_wdata = ram_rdata ^ r_lo;
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    gmt_ram #(
        .WIDTH (gmt_pkg::WORD_BITS),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gmt_word_xform u_word_xform (
        .i_word (ram_rdata),
        .i_nv   (nv_clip),
        .o_word (xf_word)
    );

    // Sequencer, configuration register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_vars  <= gmt_pkg::NUM_VARS_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_num_vars <= i_cfg_data;
            end
            // In the response state the slot is handled below, where it may be reloaded.
            if (r_out_valid && i_out_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_j      <= '0;
                        r_k      <= '0;
                        case (i_in.req_type)
                            gmt_pkg::REQ_READ: begin
                                r_res_status <= gmt_pkg::ST_READ;
                                r_res_rd     <= in_range;
                                r_state      <= S_RESP;
                            end
                            gmt_pkg::REQ_XFORM: begin
                                r_res_status <= gmt_pkg::ST_XFORM;
                                r_res_rd     <= 1'b0;
                                if (32'(r_num_vars) > MAX_VARS) begin
                                    r_n <= VAR_W'(MAX_VARS);
                                end else begin
                                    r_n <= VAR_W'(r_num_vars);
                                end
                                r_state <= S_IW_RD;
                            end
                            default: begin
                                // Writes and the unused code both report a plain write.
                                r_res_status <= gmt_pkg::ST_WRITE;
                                r_res_rd     <= 1'b0;
                                r_state      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_IW_RD: begin
                    r_state <= S_IW_WR;
                end
                S_IW_WR: begin
                    if (r_j == words_m1) begin
                        r_j <= '0;
                        if (r_n > VAR_W'(gmt_pkg::LOG_WORD)) begin
                            r_state <= S_PR_LO;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end else begin
                        r_j     <= r_j + ADDR_W'(1);
                        r_state <= S_IW_RD;
                    end
                end
                S_PR_LO: begin
                    r_state <= S_PR_HI;
                end
                S_PR_HI: begin
                    r_lo    <= ram_rdata;
                    r_state <= S_PR_WR;
                end
                S_PR_WR: begin
                    if (r_j == (words_m1 >> 1)) begin
                        r_j <= '0;
                        if (last_var) begin
                            r_state <= S_RESP;
                        end else begin
                            r_k     <= r_k + VAR_W'(1);
                            r_state <= S_PR_LO;
                        end
                    end else begin
                        r_j     <= r_j + ADDR_W'(1);
                        r_state <= S_PR_LO;
                    end
                end
                S_RESP: begin
                    // The RAM read register is not touched here, so read data stays put.
                    if (out_free) begin
                        r_out_valid     <= 1'b1;
                        r_out.read_data <= r_res_rd ? ram_rdata : '0;
                        r_out.status    <= r_res_status;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A pair write always lands on the upper word of the pair.
    a_pair_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PR_WR) |-> ((ram_waddr & kbit) != '0))
        else $error("pair write to a word with bit k clear");

    // The variable above the word boundary stays below the captured count.
    a_var_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PR_LO || r_state == S_PR_HI || r_state == S_PR_WR)
        |-> (({1'b0, r_k} + (VAR_W+1)'(gmt_pkg::LOG_WORD)) < {1'b0, r_n}))
        else $error("pair pass beyond the variable count");

    // Only a read can return non-zero data.
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != gmt_pkg::ST_READ) |-> (o_out.read_data == '0))
        else $error("non-zero data on a non-read result");

    // A result is only loaded when the output slot is free.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_out_valid && !i_out_ready) |=> (r_state == S_RESP))
        else $error("result left the response state with a full output");

    // A transfer on the input leaves the idle state, so the input is not ready in the cycle after it.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("input ready straight after a transfer");

endmodule

// ===== test/gmt_anf_checker.sv =====
// Response checker for the Moebius transform engine: mirrors the truth table and compares results.
`timescale 1ns / 1ps

module gmt_anf_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  gmt_pkg::t_req             i_in,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  gmt_pkg::t_resp            i_out,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [gmt_pkg::NV_W-1:0]  i_cfg_data,
    output int                        o_pending,
    output int                        o_fail_count
);
    import gmt_pkg::*;

    localparam int STORE_WORDS = 1 << (MAX_VARS_DEF - LOG_WORD);

    logic [WORD_BITS-1:0] truth_words [STORE_WORDS];
    logic [NV_W-1:0]      var_count;
    t_resp                due_responses [$];
    int                   fail_count = 0;

    task automatic report_mismatch(string what, logic [WORD_BITS-1:0] got,
                                   logic [WORD_BITS-1:0] want);
        $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // In-place zeta transform over the words that the current table covers.
    function automatic void run_zeta();
        int unsigned n, words, span, v, j, k, step;
        n     = (var_count > MAX_VARS_DEF) ? MAX_VARS_DEF : var_count;
        words = (n >= LOG_WORD) ? (1 << (n - LOG_WORD)) : 1;
        span  = (n >= LOG_WORD) ? WORD_BITS : (1 << n);
        for (v = 0; v < n; v++) begin
            if (v < LOG_WORD) begin
                step = 1 << v;
                for (j = 0; j < words; j++)
                    for (k = 0; k < span; k++)
                        if (k & step)
                            truth_words[j][k] = truth_words[j][k] ^ truth_words[j][k ^ step];
            end else begin
                step = 1 << (v - LOG_WORD);
                for (j = 0; j < words; j++)
                    if (j & step)
                        truth_words[j] = truth_words[j] ^ truth_words[j ^ step];
            end
        end
    endfunction

    function automatic t_resp serve_request(t_req r);
        t_resp resp;
        resp.read_data = '0;
        case (r.req_type)
            REQ_WRITE: begin
                truth_words[r.word_index] = r.write_data;
                resp.status = ST_WRITE;
            end
            REQ_READ: begin
                resp.read_data = truth_words[r.word_index];
                resp.status    = ST_READ;
            end
            REQ_XFORM: begin
                run_zeta();
                resp.status = ST_XFORM;
            end
            default: begin
                resp.status = ST_WRITE;
            end
        endcase
        return resp;
    endfunction

    always @(posedge i_clk) begin
        t_resp want;
        if (!i_rst_n) begin
            due_responses.delete();
            var_count = NUM_VARS_RST;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_responses.size() == 0) begin
                    report_mismatch("unrequested result", i_out.read_data, '0);
                end else begin
                    want = due_responses.pop_front();
                    if (i_out.read_data !== want.read_data)
                        report_mismatch("read_data", i_out.read_data, want.read_data);
                    if (i_out.status !== want.status)
                        report_mismatch("status", WORD_BITS'(i_out.status),
                                        WORD_BITS'(want.status));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                var_count = i_cfg_data;
            if (i_in_valid && i_in_ready)
                due_responses.push_back(serve_request(i_in));
        end
        o_pending    <= due_responses.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the Moebius transform engine: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb;
    import gmt_pkg::*;

    // The unused request code; the block answers it like an empty write.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int STORE_WORDS = 1 << (MAX_VARS_DEF - LOG_WORD);
    localparam int PHASE_ITEMS = 42;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1000000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_req                i_in        = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_resp               o_out;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [NV_W-1:0]     i_cfg_data  = '0;

    int                  pending;
    int                  fail_count;
    int                  cycle_count = 0;

    // Stimulus bookkeeping: which words hold data, so that no read or transform
    // ever touches a word that was never written.
    bit                  filled [STORE_WORDS];
    int                  last_written = 0;
    int                  cur_words    = 1;

    // Pacing controls shared between the sender and the receiver.
    bit                  quiet        = 1'b0;
    bit                  hold_request = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    gf2_moebius_transform_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    gmt_anf_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Word data: mostly random, with all zeros and all ones now and then so that
    // the extremes keep turning up in the random part as well.
    function automatic logic [WORD_BITS-1:0] random_word();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Offers one request and returns at the edge where it is transferred. Valid is
    // left high, so back-to-back requests need only one assignment per edge; an
    // idle gap, when one is drawn, lowers it first.
    task automatic push_request(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx,
                                logic [WORD_BITS-1:0] data);
        t_req r;
        r.req_type   = kind;
        r.word_index = idx;
        r.write_data = data;
        while (!quiet && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_word(logic [IDX_W-1:0] idx, logic [WORD_BITS-1:0] data);
        push_request(REQ_WRITE, idx, data);
        filled[idx]  = 1'b1;
        last_written = int'(idx);
    endtask

    // A transform reads every word of the current table, so each of them must
    // have been written beforehand.
    task automatic ensure_filled();
        int j;
        for (j = 0; j < cur_words; j++)
            if (!filled[j])
                write_word(IDX_W'(j), random_word());
    endtask

    // Stops offering requests and waits until every expected result has been
    // transferred, then lets the engine settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // The variable count is only changed while the engine is idle.
    task automatic set_var_count(logic [NV_W-1:0] v);
        int n;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n = (int'(v) > MAX_VARS_DEF) ? MAX_VARS_DEF : int'(v);
        cur_words = (n >= LOG_WORD) ? (1 << (n - LOG_WORD)) : 1;
    endtask

    // Receiver: accepts results at random, or always in the quiet phase, except during
    // the one long hold-off, which is counted here so that the sender keeps pushing
    // while the engine backs up and eventually refuses further transfers.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (quiet) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 17);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int                   var_plan [14];
        int                   p;
        int                   k;
        int unsigned          roll;
        logic [IDX_W-1:0]     idx;
        logic [WORD_BITS-1:0] data;

        var_plan = '{5, 0, 7, 9, 31, 2, 12, 16, 1, 6, 10, 20, 4, 8};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, still at the reset count of six variables (one word).
        write_word(0, '1);
        push_request(REQ_READ, 0, '0);
        write_word(0, '0);
        push_request(REQ_READ, 0, '1);
        write_word(IDX_W'(STORE_WORDS - 1), 64'hA5A5_5A5A_F00F_0FF0);
        push_request(REQ_READ, IDX_W'(STORE_WORDS - 1), random_word());
        push_request(REQ_UNUSED, IDX_W'(STORE_WORDS - 1), '1);
        write_word(0, {$urandom, $urandom});
        push_request(REQ_XFORM, 0, random_word());
        push_request(REQ_READ, 0, random_word());
        // Word one lies beyond a one-word table, so the transform must leave it alone.
        write_word(1, {$urandom, $urandom});
        push_request(REQ_XFORM, 1, random_word());
        push_request(REQ_READ, 1, random_word());
        push_request(REQ_READ, 0, random_word());
        // With no variables the transform is a no-op that still reports completion.
        set_var_count(0);
        push_request(REQ_XFORM, 0, '1);
        push_request(REQ_READ, 0, '0);
        // A small table occupies only the low eight bits of word zero.
        set_var_count(3);
        write_word(0, {$urandom, $urandom});
        push_request(REQ_XFORM, 0, random_word());
        push_request(REQ_READ, 0, random_word());

        // Random part: one phase per variable count, extremes and out-of-range
        // counts among them. Large tables get their transform only at phase end.
        for (p = 0; p < 14; p++) begin
            set_var_count(NV_W'(var_plan[p]));
            quiet = (p == 2);
            if (p == 3)
                hold_request = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(99);
                if ($urandom_range(3) == 0)
                    idx = IDX_W'($urandom_range(STORE_WORDS - 1));
                else
                    idx = IDX_W'($urandom_range(cur_words - 1));
                data = random_word();
                if (roll < 38) begin
                    write_word(idx, data);
                end else if (roll < 76 || (roll < 92 && cur_words > 64)) begin
                    if (!filled[idx])
                        idx = IDX_W'(last_written);
                    push_request(REQ_READ, idx, data);
                end else if (roll < 92) begin
                    ensure_filled();
                    push_request(REQ_XFORM, idx, data);
                end else begin
                    push_request(REQ_UNUSED, idx, data);
                end
            end
            ensure_filled();
            push_request(REQ_XFORM, IDX_W'($urandom_range(STORE_WORDS - 1)), random_word());
            push_request(REQ_READ, 0, random_word());
            push_request(REQ_READ, IDX_W'(cur_words - 1), random_word());
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
